>>> src/lszc_pkg.sv
// ----------------------------------------------------------------------------
// lszc_pkg: shared definitions for the zero-crossing map
// Register codes, field widths, size limits and the position record that
// travels from the raster counters to the pipeline.
// ----------------------------------------------------------------------------
package lszc_pkg;

    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_VALUE_WIDTH = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int COORD_W     = 10;

    // Smallest legal image side and the size after reset.
    localparam int MIN_IMAGE_SIZE   = 3;
    localparam int IMAGE_SIZE_RESET = 1024;

    // First row and column at which a full 3x3 window is available.
    localparam int INTERIOR_START = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_COLUMNS = 2'd0,
        REG_IMAGE_ROWS    = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic               interior;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } pos_t;

endpackage

>>> src/lszc_line_store.sv
// ----------------------------------------------------------------------------
// lszc_line_store: two-row line buffer
// One memory holds the two previous rows side by side in each entry. One
// write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lszc_line_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = 10
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/lszc_raster_ctrl.sv
// ----------------------------------------------------------------------------
// lszc_raster_ctrl: image size registers and raster counters
// Holds the clamped image size, counts columns and rows of each request and
// reports the position of the pixel to be decided.
// ----------------------------------------------------------------------------
module lszc_raster_ctrl #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_write,
    input  logic [lszc_pkg::CFG_INDEX_W-1:0]           cfg_index,
    input  logic [lszc_pkg::CFG_DATA_W-1:0]            cfg_data,
    input  logic                                       advance,
    output logic                                       restart,
    output lszc_pkg::pos_t                             pos,
    output logic [$clog2(MAX_COLUMNS)-1:0]             addr
);
    import lszc_pkg::*;

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CSW   = $clog2(MAX_COLUMNS + 1);
    localparam int RSW   = $clog2(MAX_ROWS + 1);
    localparam int CCMPW = (CSW > CFG_DATA_W) ? CSW : CFG_DATA_W;
    localparam int RCMPW = (RSW > CFG_DATA_W) ? RSW : CFG_DATA_W;
    localparam int COLS_RESET = (IMAGE_SIZE_RESET > MAX_COLUMNS) ? MAX_COLUMNS
                                                                 : IMAGE_SIZE_RESET;
    localparam int ROWS_RESET = (IMAGE_SIZE_RESET > MAX_ROWS) ? MAX_ROWS
                                                              : IMAGE_SIZE_RESET;

    logic [CSW-1:0]   cols_reg, cols_next;
    logic [RSW-1:0]   rows_reg, rows_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [CCMPW-1:0] cdata_ext;
    logic [RCMPW-1:0] rdata_ext;
    logic [CSW-1:0]   cols_clamped;
    logic [RSW-1:0]   rows_clamped;
    logic             hit_cols;
    logic             hit_rows;

    assign cdata_ext = CCMPW'(cfg_data);
    assign rdata_ext = RCMPW'(cfg_data);

    always_comb
    begin
        if (cdata_ext < CCMPW'(MIN_IMAGE_SIZE))
            cols_clamped = CSW'(MIN_IMAGE_SIZE);
        else if (cdata_ext > CCMPW'(MAX_COLUMNS))
            cols_clamped = CSW'(MAX_COLUMNS);
        else
            cols_clamped = CSW'(cdata_ext);

        if (rdata_ext < RCMPW'(MIN_IMAGE_SIZE))
            rows_clamped = RSW'(MIN_IMAGE_SIZE);
        else if (rdata_ext > RCMPW'(MAX_ROWS))
            rows_clamped = RSW'(MAX_ROWS);
        else
            rows_clamped = RSW'(rdata_ext);
    end

    always_comb
    begin
        hit_cols = 1'b0;
        hit_rows = 1'b0;
        case (cfg_index)
            REG_IMAGE_COLUMNS: hit_cols = cfg_write;
            REG_IMAGE_ROWS:    hit_rows = cfg_write;
            default:           ;
        endcase
    end

    assign restart = hit_cols | hit_rows;

    always_comb
    begin
        cols_next = hit_cols ? cols_clamped : cols_reg;
        rows_next = hit_rows ? rows_clamped : rows_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (advance)
        begin
            if (CSW'(col_reg) == cols_reg - CSW'(1))
            begin
                col_next = '0;
                if (RSW'(row_reg) == rows_reg - RSW'(1))
                    row_next = '0;
                else
                    row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CSW'(COLS_RESET);
            rows_reg <= RSW'(ROWS_RESET);
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

    // The decided pixel sits one row up and one column left of the arrival.
    assign pos.interior = (row_reg >= RW'(INTERIOR_START)) &&
                          (col_reg >= CW'(INTERIOR_START));
    assign pos.row      = COORD_W'(row_reg - RW'(1));
    assign pos.col      = COORD_W'(col_reg - CW'(1));
    assign addr         = col_reg;

endmodule

>>> src/lszc_window.sv
// ----------------------------------------------------------------------------
// lszc_window: 3x3 window and zero-crossing decision
// Keeps the two older window columns and decides the centre pixel from
// them and the incoming column.
// ----------------------------------------------------------------------------
module lszc_window #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          shift,
    input  logic signed [VALUE_WIDTH-1:0] top,
    input  logic signed [VALUE_WIDTH-1:0] mid,
    input  logic signed [VALUE_WIDTH-1:0] bot,
    output logic                          edge_hit
);

    localparam int VW = VALUE_WIDTH;
    localparam int NB = 8;

    logic signed [VW-1:0] win_reg  [6];
    logic signed [VW-1:0] win_next [6];
    logic signed [VW-1:0] nb [NB];
    logic signed [VW-1:0] centre;
    logic [VW:0]          centre_mag;
    logic                 centre_pos;
    logic                 any_nonzero;
    logic                 any_cross;
    logic [VW:0]          nb_mag [NB];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
            win_next[i] = win_reg[i];
        if (clear)
        begin
            for (int i = 0; i < 6; i++)
                win_next[i] = '0;
        end
        else if (shift)
        begin
            win_next[0] = win_reg[3];
            win_next[1] = win_reg[4];
            win_next[2] = win_reg[5];
            win_next[3] = top;
            win_next[4] = mid;
            win_next[5] = bot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= win_next[i];
        end
    end

    assign nb[0]  = win_reg[0];
    assign nb[1]  = win_reg[3];
    assign nb[2]  = top;
    assign nb[3]  = win_reg[1];
    assign nb[4]  = mid;
    assign nb[5]  = win_reg[2];
    assign nb[6]  = win_reg[5];
    assign nb[7]  = bot;
    assign centre = win_reg[4];

    // Magnitudes carry one extra bit so the most negative value ranks highest.
    assign centre_mag = centre[VW-1] ? (VW+1)'(-$signed({centre[VW-1], centre}))
                                     : (VW+1)'(centre);
    assign centre_pos = !centre[VW-1] && (centre != '0);

    always_comb
    begin
        any_nonzero = 1'b0;
        any_cross   = 1'b0;
        for (int k = 0; k < NB; k++)
        begin
            nb_mag[k] = nb[k][VW-1] ? (VW+1)'(-$signed({nb[k][VW-1], nb[k]}))
                                    : (VW+1)'(nb[k]);
            if (nb[k] != '0)
                any_nonzero = 1'b1;
            if ((centre_mag < nb_mag[k]) &&
                (centre_pos != (!nb[k][VW-1] && (nb[k] != '0))))
                any_cross = 1'b1;
        end
    end

    assign edge_hit = (centre == '0) ? any_nonzero : any_cross;

endmodule

>>> src/level_set_zero_crossing_map.sv
// ----------------------------------------------------------------------------
// level_set_zero_crossing_map: streaming 3x3 zero-crossing detector
// Takes level-set values in raster order and marks each interior pixel that
// lies on a zero crossing.
//
//   Channel  Direction  Handshake             Payload
//   in       sink       in_valid / in_stall   phi_value
//   out      source     out_valid / out_stall edge_flag, pixel_row, pixel_column
//   cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One pixel is taken every clock while in_stall is low. A pixel is registered
// in the input stage, where the line store read completes, and its result
// then moves into the output register.
// Reset clears the counters and the window and sets each size to 1024, or to
// its maximum if smaller; the line store needs no clearing as the first two
// rows fill it. A stalled output holds its result and stalls the input only
// once the input stage is also occupied.
// ----------------------------------------------------------------------------
module level_set_zero_crossing_map #(
    parameter int MAX_COLUMNS = lszc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = lszc_pkg::DEF_MAX_ROWS,
    parameter int VALUE_WIDTH = lszc_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [VALUE_WIDTH-1:0]       phi_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                edge_flag,
    output logic [lszc_pkg::COORD_W-1:0]        pixel_row,
    output logic [lszc_pkg::COORD_W-1:0]        pixel_column,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lszc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lszc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lszc_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int AW = $clog2(MAX_COLUMNS);

    logic              accept;
    logic              advance;
    logic              out_free;
    logic              restart;
    pos_t              cur_pos;
    logic [AW-1:0]     cur_addr;
    logic [2*VW-1:0]   rd_data;
    logic signed [VW-1:0] top;
    logic signed [VW-1:0] mid;
    logic              edge_hit;

    logic              s1_valid_reg, s1_valid_next;
    logic signed [VW-1:0] s1_bot_reg;
    pos_t              s1_pos_reg;
    logic [AW-1:0]     s1_addr_reg;

    logic              out_valid_reg, out_valid_next;
    logic              edge_flag_reg;
    logic [COORD_W-1:0] pixel_row_reg;
    logic [COORD_W-1:0] pixel_column_reg;

    assign cfg_ready = 1'b1;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    lszc_raster_ctrl #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_raster_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .restart   (restart),
        .pos       (cur_pos),
        .addr      (cur_addr)
    );

    // Each entry holds {row r-2, row r-1} for one column.
    lszc_line_store #(
        .DEPTH (MAX_COLUMNS),
        .WIDTH (2 * VW),
        .AW    (AW)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (advance),
        .wr_addr (s1_addr_reg),
        .wr_data ({mid, s1_bot_reg}),
        .rd_en   (accept),
        .rd_addr (cur_addr),
        .rd_data (rd_data)
    );

    assign top = rd_data[2*VW-1:VW];
    assign mid = rd_data[VW-1:0];

    lszc_window #(
        .VALUE_WIDTH (VW)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (restart),
        .shift    (advance),
        .top      (top),
        .mid      (mid),
        .bot      (s1_bot_reg),
        .edge_hit (edge_hit)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = s1_pos_reg.interior;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bot_reg  <= phi_value;
            s1_pos_reg  <= cur_pos;
            s1_addr_reg <= cur_addr;
        end
        if (advance && s1_pos_reg.interior)
        begin
            edge_flag_reg    <= edge_hit;
            pixel_row_reg    <= s1_pos_reg.row;
            pixel_column_reg <= s1_pos_reg.col;
        end
    end

    assign out_valid    = out_valid_reg;
    assign edge_flag    = edge_flag_reg;
    assign pixel_row    = pixel_row_reg;
    assign pixel_column = pixel_column_reg;

    // The input stage is never overwritten while its pixel is still waiting.
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |-> in_stall)
        else $error("input stage overwritten while held");

    // A line store write never hits the column being read in the same cycle.
    a_no_rw_collision : assert property (@(posedge clk) disable iff (!rst_n)
        advance && accept |-> s1_addr_reg != cur_addr)
        else $error("line store read and write at the same column");

    // A new result comes only from an interior pixel leaving the input stage.
    a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg && out_valid_next |-> advance && s1_pos_reg.interior)
        else $error("result raised without an interior pixel");

endmodule

>>> test/level_set_zero_crossing_map_tb.sv
// ----------------------------------------------------------------------------
// level_set_zero_crossing_map_tb: self-checking bench for the zero-crossing map
// Streams level-set pixels through the block under several image sizes,
// predicts each interior decision from its own copy of the line stores and
// window, and compares every result in order with random stalls on both sides.
// ----------------------------------------------------------------------------
module level_set_zero_crossing_map_tb;

    import lszc_pkg::*;

    localparam int VW            = DEF_VALUE_WIDTH;
    localparam int SETTLE_CYCLES = 6;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int WIDE_ITEMS    = 100;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic signed [VW-1:0] PHI_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] PHI_MAX = {1'b0, {(VW-1){1'b1}}};

    typedef struct packed {
        logic               flag;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } crossing_t;

    class crossing_scoreboard;
        int unsigned columns_reg;
        int unsigned rows_reg;
        int          older_line[DEF_MAX_COLUMNS];
        int          recent_line[DEF_MAX_COLUMNS];
        int          window[6];
        int unsigned col_cnt;
        int unsigned row_cnt;
        crossing_t   expected_q[$];
        int          errors;

        function void restart_frame();
            col_cnt = 0;
            row_cnt = 0;
            foreach (window[i]) window[i] = 0;
        endfunction

        function void power_on();
            columns_reg = IMAGE_SIZE_RESET;
            rows_reg    = IMAGE_SIZE_RESET;
            foreach (older_line[i]) older_line[i] = 0;
            foreach (recent_line[i]) recent_line[i] = 0;
            restart_frame();
            errors = 0;
        endfunction

        function int unsigned effective_size(int unsigned raw, int unsigned hi);
            if (raw < MIN_IMAGE_SIZE) return MIN_IMAGE_SIZE;
            if (raw > hi) return hi;
            return raw;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_IMAGE_COLUMNS)
            begin
                columns_reg = data;
                restart_frame();
            end
            else if (idx == REG_IMAGE_ROWS)
            begin
                rows_reg = data;
                restart_frame();
            end
        endfunction

        function void note_pixel(logic signed [VW-1:0] phi);
            int unsigned cols;
            int unsigned rows;
            int unsigned ci;
            int          top;
            int          mid;
            int          bot;
            int          centre;
            int          cmag;
            int          nmag;
            int          nb[8];
            bit          hit;
            crossing_t   want;
            cols = effective_size(columns_reg, DEF_MAX_COLUMNS);
            rows = effective_size(rows_reg, DEF_MAX_ROWS);
            ci   = col_cnt % DEF_MAX_COLUMNS;
            top  = older_line[ci];
            mid  = recent_line[ci];
            bot  = phi;
            if (row_cnt >= INTERIOR_START && col_cnt >= INTERIOR_START)
            begin
                nb     = '{window[0], window[3], top, window[1], mid, window[2], window[5], bot};
                centre = window[4];
                cmag   = (centre < 0) ? -centre : centre;
                hit    = 1'b0;
                foreach (nb[k])
                begin
                    nmag = (nb[k] < 0) ? -nb[k] : nb[k];
                    if (centre == 0)
                    begin
                        if (nb[k] != 0) hit = 1'b1;
                    end
                    else if (cmag < nmag && ((centre > 0) != (nb[k] > 0)))
                    begin
                        hit = 1'b1;
                    end
                end
                want.flag = hit;
                want.row  = COORD_W'(row_cnt - 1);
                want.col  = COORD_W'(col_cnt - 1);
                expected_q.push_back(want);
            end
            window[0] = window[3];
            window[1] = window[4];
            window[2] = window[5];
            window[3] = top;
            window[4] = mid;
            window[5] = bot;
            older_line[ci]  = mid;
            recent_line[ci] = bot;
            col_cnt++;
            if (col_cnt >= cols)
            begin
                col_cnt = 0;
                row_cnt++;
                if (row_cnt >= rows) row_cnt = 0;
            end
        endfunction

        function void check_result(logic flag, logic [COORD_W-1:0] row,
                                   logic [COORD_W-1:0] col);
            crossing_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result edge_flag=%0d pixel_row=%0d pixel_column=%0d",
                         $time, flag, row, col);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (flag !== want.flag)
            begin
                $display("%0t: edge_flag at (%0d,%0d) expected %0d, actual %0d",
                         $time, want.row, want.col, want.flag, flag);
                errors++;
            end
            if (row !== want.row)
            begin
                $display("%0t: pixel_row expected %0d, actual %0d", $time, want.row, row);
                errors++;
            end
            if (col !== want.col)
            begin
                $display("%0t: pixel_column expected %0d, actual %0d", $time, want.col, col);
                errors++;
            end
        endfunction
    endclass

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    in_valid     = 1'b0;
    logic                    in_stall;
    logic signed [VW-1:0]    phi_value    = '0;
    logic                    out_valid;
    logic                    out_stall    = 1'b0;
    logic                    edge_flag;
    logic [COORD_W-1:0]      pixel_row;
    logic [COORD_W-1:0]      pixel_column;
    logic                    cfg_valid    = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0]   cfg_data     = '0;

    bit                      quiet        = 1'b0;
    int                      idle_cycles  = 0;
    crossing_scoreboard      sb           = new;

    // Three columns per row: each row after the second decides its middle pixel.
    int directed_phi[27] = '{
        0, 0, 0,
        0, 0, 0,
        0, 0, 0,
        0, 0, -1,
        7, 7, 7,
        7, -7, 7,
        9, 9, 9,
        32767, -32768, -9,
        32767, 32767, 32767
    };

    level_set_zero_crossing_map uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .phi_value    (phi_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .edge_flag    (edge_flag),
        .pixel_row    (pixel_row),
        .pixel_column (pixel_column),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 29);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(edge_flag, pixel_row, pixel_column);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_MAX);
                $display("Test completed with failures");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic logic signed [VW-1:0] pick_phi();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return VW'($urandom);
            4, 5, 6:    return VW'($urandom_range(0, 4) - 2);
            7:          return '0;
            8:          return $urandom_range(0, 1) ? PHI_MIN : PHI_MAX;
            default:    return $urandom_range(0, 1) ? VW'(1) : VW'(-1);
        endcase
    endfunction

    task automatic send_pixel(logic signed [VW-1:0] phi);
        while (!quiet && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        phi_value <= phi;
        do @(posedge clk); while (in_stall);
        sb.note_pixel(phi);
    endtask

    // A pixel on the border leaves no result behind, so some cycles are
    // allowed for the pipeline to empty after the last expected result.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic start_phase(bit resize, logic [CFG_DATA_W-1:0] cols,
                               logic [CFG_DATA_W-1:0] rows, logic [CFG_INDEX_W-1:0] spare);
        drain_results();
        if (!resize)
        begin
            write_reg(spare, CFG_DATA_W'($urandom));
        end
        else if ($urandom_range(0, 1))
        begin
            write_reg(REG_IMAGE_COLUMNS, cols);
            write_reg(REG_IMAGE_ROWS, rows);
        end
        else
        begin
            write_reg(REG_IMAGE_ROWS, rows);
            write_reg(REG_IMAGE_COLUMNS, cols);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned             n_items;
        int unsigned             pick;
        logic [CFG_DATA_W-1:0]   cols_data;
        logic [CFG_DATA_W-1:0]   rows_data;
        logic [CFG_INDEX_W-1:0]  spare;
        bit                      resize;

        sb.power_on();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both sizes out of range: columns clamp up to three, rows down to the maximum.
        start_phase(1'b1, '0, '1, REG_SPARE_A);
        foreach (directed_phi[i]) send_pixel(VW'(directed_phi[i]));

        for (int p = 0; p < 12; p++)
        begin
            resize    = !(p == 2 || p == 5 || $urandom_range(0, 4) == 0);
            cols_data = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                                    : CFG_DATA_W'($urandom_range(3, 12));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                rows_data = CFG_DATA_W'($urandom_range(0, 2));
            else if (pick == 1)
                rows_data = CFG_DATA_W'($urandom_range(1025, 2047));
            else
                rows_data = CFG_DATA_W'($urandom_range(3, 10));
            if (p == 2)
                spare = REG_SPARE_A;
            else if (p == 5)
                spare = REG_SPARE_B;
            else
                spare = $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
            quiet = (p >= 6 && p <= 8);
            start_phase(resize, cols_data, rows_data, spare);
            n_items = $urandom_range(40, 110);
            for (int i = 0; i < n_items; i++)
            begin
                if (i == n_items / 2 && (p == 0 || $urandom_range(0, 3) == 0))
                    drain_results();
                send_pixel(pick_phi());
            end
        end
        quiet = 1'b0;

        // Columns above the maximum clamp to it, so a short first row gives no result.
        start_phase(1'b1, CFG_DATA_W'($urandom_range(1025, 2047)), CFG_DATA_W'(3),
                    REG_SPARE_B);
        for (int i = 0; i < WIDE_ITEMS; i++) send_pixel(pick_phi());

        drain_results();
        if (sb.expected_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
        end
        if (sb.errors == 0 && sb.expected_q.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
